@@ rtl/core/bst_pkg.sv @@
package bst_pkg;

    // Default sizing
    localparam int STACK_DEPTH_DEF = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int TOKV_W  = 32;
    localparam int DEPTH_W = 6;
    localparam int CODE_W  = 3;
    localparam int LEN_W   = 31;
    localparam int TDATA_OUT_W = 48;

    localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST = 6'd32;
    localparam logic [LEN_W-1:0]   LEN_CAP       = 31'h7FFF_FFFF;

    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [CODE_W-1:0] code_t;
    typedef logic [2:0]        mode_t;
    typedef logic [1:0]        entry_t;

    // Token kinds
    localparam kind_t KIND_INT   = 3'd0;
    localparam kind_t KIND_STR   = 3'd1;
    localparam kind_t KIND_BYTE  = 3'd2;
    localparam kind_t KIND_LIST  = 3'd3;
    localparam kind_t KIND_DICT  = 3'd4;
    localparam kind_t KIND_CLOSE = 3'd5;
    localparam kind_t KIND_ERR   = 3'd6;

    // Error codes
    localparam code_t ERR_NONE     = 3'd0;
    localparam code_t ERR_BAD_TYPE = 3'd1;
    localparam code_t ERR_BAD_KEY  = 3'd2;
    localparam code_t ERR_TRUNC    = 3'd3;
    localparam code_t ERR_DEPTH    = 3'd4;
    localparam code_t ERR_OVFL     = 3'd5;

    // Parser modes
    localparam mode_t MODE_VALUE = 3'd0;
    localparam mode_t MODE_INT   = 3'd1;
    localparam mode_t MODE_LEN   = 3'd2;
    localparam mode_t MODE_STR   = 3'd3;
    localparam mode_t MODE_ERR   = 3'd4;

    // Nesting stack entries
    localparam entry_t ENT_NONE = 2'd0;
    localparam entry_t ENT_LIST = 2'd1;
    localparam entry_t ENT_DKEY = 2'd2;
    localparam entry_t ENT_DVAL = 2'd3;

    // Number phases
    localparam logic [1:0] PH_SPACE = 2'd0;
    localparam logic [1:0] PH_SIGN  = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;
    localparam logic [1:0] PH_SKIP  = 2'd3;

    // Characters
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

endpackage

@@ rtl/core/bencode_stream_tokenizer.sv @@
// Channel | Dir | Handshake             | Payload
// s_      | in  | s_tvalid / s_tready   | s_tdata = data_byte, s_tlast = last_byte
// m_      | out | m_tvalid / m_tready   | m_tdata = value/flags, m_tuser = kind, m_tlast = end
// cfg_    | in  | cfg_valid / cfg_ready | cfg_data = max_depth
//
// Throughput is one byte per cycle while m_ is not stalled. A request is captured in the
// input register and any token it yields is then loaded into the result register, which
// drives m_; the step (stack top, times-ten multiply-add and compare) sits between.
// aresetn is synchronous, active low, and clears parser state and max_depth
// to 32; the stack memory is not cleared. A stalled m_ side holds the result
// register and backs up into the input register, then s_tready drops.
module bencode_stream_tokenizer
    import bst_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input bytes
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [BYTE_W-1:0]      s_tdata,   // [7:0] data_byte
    input  logic                   s_tlast,   // last_byte
    // tokens
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,   // [31:0] token_value, [32] string_end,
                                              // [33] is_key, [39:34] nest_depth,
                                              // [42:40] error_code, [47:43] zero
    output logic [KIND_W-1:0]      m_tuser,   // [2:0] token_kind
    output logic                   m_tlast,   // message_end
    // configuration
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [DEPTH_W-1:0]     cfg_data   // max_depth
);

    localparam int SPW  = $clog2(STACK_DEPTH + 1);
    localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int ACCW = (VALUE_WIDTH > TOKV_W) ? VALUE_WIDTH : TOKV_W;
    localparam int MW   = ACCW + 4;
    localparam logic [MW-1:0] INT_LIM = MW'(1) << (VALUE_WIDTH - 1);
    localparam logic [MW-1:0] LEN_LIM = MW'(LEN_CAP);
    localparam logic [SPW+DEPTH_W-1:0] STK_LIM = (SPW+DEPTH_W)'(STACK_DEPTH);

    // Input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_data_reg;
    logic              in_last_reg;
    logic              adv;

    // Parser state
    mode_t            mode_reg, mode_next;
    logic [ACCW-1:0]  acc_reg, acc_next;
    logic             sign_reg, sign_next;
    logic [1:0]       phase_reg, phase_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [SPW-1:0]   sp_reg, sp_next;
    entry_t           top_reg, top_next;
    entry_t           below_reg;
    logic             key_reg, key_next;
    logic [DEPTH_W-1:0] max_depth_reg;

    // Entries below the cached top of stack
    entry_t stack_mem [STACK_DEPTH];

    // Result register
    logic               m_valid_reg;
    kind_t              o_kind_reg, o_kind_next;
    logic [TOKV_W-1:0]  o_value_reg, o_value_next;
    logic               o_send_reg, o_send_next;
    logic               o_key_reg, o_key_next;
    logic [DEPTH_W-1:0] o_depth_reg, o_depth_next;
    code_t              o_code_reg, o_code_next;
    logic               o_last_reg;
    logic               have;

    // Step helpers
    logic [BYTE_W-1:0]        b;
    logic                     is_dig, is_spc;
    logic [3:0]               dig;
    entry_t                   top;
    logic [MW-1:0]            mac, int_cap;
    logic [ACCW-1:0]          neg_acc;
    logic [SPW+DEPTH_W-1:0]   sp_wide, spn_wide, md_wide;
    logic                     too_deep;
    logic                     do_push;
    logic [SPW-1:0]           sp_dec, rd_full;
    logic [AW-1:0]            wr_addr, rd_addr;

    assign adv       = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Hold the byte until the step takes it
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_depth_reg <= MAX_DEPTH_RST;
        end else if (cfg_valid) begin
            max_depth_reg <= cfg_data;
        end
    end

    assign b      = in_data_reg;
    assign is_dig = (b >= CH_0) && (b <= CH_9);
    assign is_spc = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    assign dig    = b[3:0];
    assign top    = (sp_reg != '0) ? top_reg : ENT_NONE;

    // Times ten plus digit, by shift-add
    assign mac     = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + MW'(dig);
    assign int_cap = sign_reg ? INT_LIM : (INT_LIM - MW'(1));
    assign neg_acc = '0 - acc_reg;

    assign sp_wide  = {{DEPTH_W{1'b0}}, sp_reg};
    assign md_wide  = {{SPW{1'b0}}, max_depth_reg};
    assign too_deep = (sp_wide >= md_wide) || (sp_wide >= STK_LIM);

    always_comb begin
        mode_next    = mode_reg;
        acc_next     = acc_reg;
        sign_next    = sign_reg;
        phase_next   = phase_reg;
        rem_next     = rem_reg;
        sp_next      = sp_reg;
        top_next     = top_reg;
        key_next     = key_reg;
        do_push      = 1'b0;
        have         = 1'b0;
        o_kind_next  = KIND_INT;
        o_value_next = '0;
        o_send_next  = 1'b0;
        o_key_next   = 1'b0;
        o_code_next  = ERR_NONE;

        case (mode_reg)
            MODE_VALUE: begin
                if (top == ENT_DKEY && is_dig) begin
                    mode_next  = MODE_LEN;
                    acc_next   = ACCW'(dig);
                    phase_next = PH_DIGIT;
                    key_next   = 1'b1;
                end else if (b == CH_E && (top == ENT_DKEY || top == ENT_LIST)) begin
                    // Close: pop, reveal the parent and finish its value
                    sp_next     = sp_reg - 1'b1;
                    have        = 1'b1;
                    o_kind_next = KIND_CLOSE;
                    top_next    = below_reg;
                    if (sp_next != '0 && below_reg == ENT_DVAL) begin
                        top_next = ENT_DKEY;
                    end
                end else if (top == ENT_DKEY) begin
                    have        = 1'b1;
                    o_kind_next = KIND_ERR;
                    o_code_next = ERR_BAD_KEY;
                    mode_next   = MODE_ERR;
                end else if (b == CH_I) begin
                    mode_next  = MODE_INT;
                    acc_next   = '0;
                    sign_next  = 1'b0;
                    phase_next = PH_SPACE;
                end else if (b == CH_L || b == CH_D) begin
                    have = 1'b1;
                    if (too_deep) begin
                        o_kind_next = KIND_ERR;
                        o_code_next = ERR_DEPTH;
                        mode_next   = MODE_ERR;
                    end else begin
                        do_push     = 1'b1;
                        sp_next     = sp_reg + 1'b1;
                        top_next    = (b == CH_L) ? ENT_LIST : ENT_DKEY;
                        o_kind_next = (b == CH_L) ? KIND_LIST : KIND_DICT;
                    end
                end else if (is_dig) begin
                    mode_next  = MODE_LEN;
                    acc_next   = ACCW'(dig);
                    phase_next = PH_DIGIT;
                    key_next   = 1'b0;
                end else begin
                    have        = 1'b1;
                    o_kind_next = KIND_ERR;
                    o_code_next = ERR_BAD_TYPE;
                    mode_next   = MODE_ERR;
                end
            end
            MODE_INT: begin
                if (b == CH_E) begin
                    have         = 1'b1;
                    o_kind_next  = KIND_INT;
                    o_value_next = sign_reg ? neg_acc[TOKV_W-1:0] : acc_reg[TOKV_W-1:0];
                    mode_next    = MODE_VALUE;
                    if (top == ENT_DVAL) begin
                        top_next = ENT_DKEY;
                    end
                end else if (phase_reg == PH_SPACE && is_spc) begin
                    phase_next = PH_SPACE;
                end else if (phase_reg == PH_SPACE && (b == CH_PLUS || b == CH_MINUS)) begin
                    sign_next  = (b == CH_MINUS);
                    phase_next = PH_SIGN;
                end else if (phase_reg != PH_SKIP && is_dig) begin
                    phase_next = PH_DIGIT;
                    // Saturate at the signed range limit
                    acc_next   = (mac > int_cap) ? int_cap[ACCW-1:0] : mac[ACCW-1:0];
                end else begin
                    phase_next = PH_SKIP;
                end
            end
            MODE_LEN: begin
                if (b == CH_COLON) begin
                    have         = 1'b1;
                    o_kind_next  = KIND_STR;
                    o_value_next = acc_reg[TOKV_W-1:0];
                    o_send_next  = (acc_reg[LEN_W-1:0] == '0);
                    o_key_next   = key_reg;
                    if (acc_reg[LEN_W-1:0] == '0) begin
                        mode_next = MODE_VALUE;
                        if (key_reg) begin
                            if (sp_reg != '0) begin
                                top_next = ENT_DVAL;
                            end
                            key_next = 1'b0;
                        end else if (top == ENT_DVAL) begin
                            top_next = ENT_DKEY;
                        end
                    end else begin
                        mode_next = MODE_STR;
                        rem_next  = acc_reg[LEN_W-1:0];
                    end
                end else if (phase_reg == PH_DIGIT && is_dig) begin
                    if (mac > LEN_LIM) begin
                        have        = 1'b1;
                        o_kind_next = KIND_ERR;
                        o_code_next = ERR_OVFL;
                        mode_next   = MODE_ERR;
                    end else begin
                        acc_next = mac[ACCW-1:0];
                    end
                end else begin
                    phase_next = PH_SKIP;
                end
            end
            MODE_STR: begin
                rem_next     = rem_reg - 1'b1;
                have         = 1'b1;
                o_kind_next  = KIND_BYTE;
                o_value_next = TOKV_W'(b);
                o_send_next  = (rem_reg == LEN_W'(1));
                o_key_next   = key_reg;
                if (rem_reg == LEN_W'(1)) begin
                    mode_next = MODE_VALUE;
                    if (key_reg) begin
                        if (sp_reg != '0) begin
                            top_next = ENT_DVAL;
                        end
                        key_next = 1'b0;
                    end else if (top == ENT_DVAL) begin
                        top_next = ENT_DKEY;
                    end
                end
            end
            default: begin
                // Error mode: drop bytes until the message ends
            end
        endcase

        // Truncated message replaces any non-error token of the final byte
        if (in_last_reg && mode_reg != MODE_ERR && !(have && o_kind_next == KIND_ERR) &&
            (mode_next != MODE_VALUE || sp_next != '0)) begin
            have         = 1'b1;
            o_kind_next  = KIND_ERR;
            o_value_next = '0;
            o_send_next  = 1'b0;
            o_key_next   = 1'b0;
            o_code_next  = ERR_TRUNC;
            mode_next    = MODE_ERR;
        end

        spn_wide     = {{DEPTH_W{1'b0}}, sp_next};
        o_depth_next = spn_wide[DEPTH_W-1:0];

        if (in_last_reg) begin
            mode_next  = MODE_VALUE;
            acc_next   = '0;
            sign_next  = 1'b0;
            phase_next = PH_SPACE;
            rem_next   = '0;
            sp_next    = '0;
            key_next   = 1'b0;
        end
    end

    assign sp_dec  = sp_reg - 1'b1;
    assign wr_addr = sp_dec[AW-1:0];
    assign rd_full = sp_next - SPW'(2);
    assign rd_addr = rd_full[AW-1:0];

    // Spill the old top on a push; keep the next-lower entry read ahead
    always_ff @(posedge aclk) begin
        if (adv && do_push && sp_reg != '0) begin
            stack_mem[wr_addr] <= top_reg;
        end
        if (adv) begin
            if (do_push) begin
                below_reg <= top_reg;
            end else begin
                below_reg <= stack_mem[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_VALUE;
            acc_reg   <= '0;
            sign_reg  <= 1'b0;
            phase_reg <= PH_SPACE;
            rem_reg   <= '0;
            sp_reg    <= '0;
            top_reg   <= ENT_NONE;
            key_reg   <= 1'b0;
        end else if (adv) begin
            mode_reg  <= mode_next;
            acc_reg   <= acc_next;
            sign_reg  <= sign_next;
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            sp_reg    <= sp_next;
            top_reg   <= top_next;
            key_reg   <= key_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= have;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && have) begin
            o_kind_reg  <= o_kind_next;
            o_value_reg <= o_value_next;
            o_send_reg  <= o_send_next;
            o_key_reg   <= o_key_next;
            o_depth_reg <= o_depth_next;
            o_code_reg  <= o_code_next;
            o_last_reg  <= in_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {5'b0, o_code_reg, o_depth_reg, o_key_reg, o_send_reg, o_value_reg};

`ifndef SYNTHESIS
    // Error tokens carry a code, other tokens never do
    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((o_kind_reg == KIND_ERR) == (o_code_reg != ERR_NONE)))
        else $error("error_code does not match token kind");

    // string_end only on string tokens
    a_send_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && o_send_reg) |-> (o_kind_reg == KIND_STR || o_kind_reg == KIND_BYTE))
        else $error("string_end on a non-string token");

    // The final byte leaves the parser at top level
    a_msg_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && in_last_reg) |=> (sp_reg == '0 && mode_reg == MODE_VALUE && !key_reg))
        else $error("parser state not cleared at message end");

    // Stack pointer stays within the stack
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> (sp_wide <= STK_LIM))
        else $error("stack pointer beyond stack depth");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import bst_pkg::*;

    localparam int STK         = STACK_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 4;     // two register stages plus margin

    // One token as the block presents it on the m_ side.
    typedef struct packed {
        kind_t              kind;
        logic [TOKV_W-1:0]  value;
        logic               str_end;
        logic               key;
        logic [DEPTH_W-1:0] depth;
        code_t              code;
        logic               msg_end;
    } token_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic [KIND_W-1:0]      m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [DEPTH_W-1:0]     cfg_data;

    bencode_stream_tokenizer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // Parser mirror: its own copy of the depth limit and parse state.
    // ------------------------------------------------------------------
    logic [DEPTH_W-1:0] depth_cfg;
    mode_t              p_mode;
    logic [63:0]        p_acc;
    bit                 p_neg;
    logic [1:0]         p_phase;
    logic [31:0]        p_left;
    entry_t             p_nest [STK];
    int                 p_sp;
    bit                 p_key;
    bit                 p_have;
    token_t             p_tok;
    int                 parsed_bytes;

    token_t             expected_tokens [$];
    token_t             want;
    int                 token_count;
    int                 fail_count;
    int                 cycle_count;

    // Stimulus controls shared by the test tasks and the token sink.
    logic [7:0]         msg [$];
    entry_t             plan_stk [$];
    bit                 tx_idle;
    bit                 rx_idle;
    int                 rx_hold_req;
    int                 rx_stall;

    function automatic bit is_dig(logic [7:0] b);
        return b >= CH_0 && b <= CH_9;
    endfunction

    function automatic void clear_parser();
        p_mode  = MODE_VALUE;
        p_acc   = '0;
        p_neg   = 1'b0;
        p_phase = PH_SPACE;
        p_left  = '0;
        p_sp    = 0;
        p_key   = 1'b0;
    endfunction

    function automatic void tok_set(kind_t k, logic [63:0] v, bit se, bit ky);
        p_have        = 1'b1;
        p_tok.kind    = k;
        p_tok.value   = v[31:0];
        p_tok.str_end = se;
        p_tok.key     = ky;
        p_tok.code    = ERR_NONE;
    endfunction

    // Raise an error token and drop everything up to the end of the message.
    function automatic void tok_error(code_t c);
        tok_set(KIND_ERR, 64'd0, 1'b0, 1'b0);
        p_tok.code = c;
        p_mode     = MODE_ERR;
    endfunction

    // A finished dictionary value turns the level back to key position.
    function automatic void value_closed();
        if (p_sp > 0 && p_nest[p_sp-1] == ENT_DVAL)
            p_nest[p_sp-1] = ENT_DKEY;
    endfunction

    function automatic void string_closed();
        p_mode = MODE_VALUE;
        if (p_key) begin
            if (p_sp > 0)
                p_nest[p_sp-1] = ENT_DVAL;
            p_key = 1'b0;
        end else begin
            value_closed();
        end
    endfunction

    function automatic void start_len(logic [7:0] dig, bit ky);
        p_mode  = MODE_LEN;
        p_acc   = {56'd0, dig};
        p_phase = PH_DIGIT;
        p_key   = ky;
    endfunction

    function automatic void open_nest(entry_t e, kind_t k);
        int limit;
        limit = (depth_cfg < STK) ? int'(depth_cfg) : STK;
        if (p_sp >= limit) begin
            tok_error(ERR_DEPTH);
        end else begin
            p_nest[p_sp] = e;
            p_sp++;
            tok_set(k, 64'd0, 1'b0, 1'b0);
        end
    endfunction

    function automatic void close_nest();
        p_sp--;
        tok_set(KIND_CLOSE, 64'd0, 1'b0, 1'b0);
        value_closed();
    endfunction

    // Advance the mirror by one byte; return 1 when the byte yields a token.
    function automatic bit tokenize_byte(logic [7:0] b, bit last);
        bit          was_err;
        entry_t      top;
        logic [63:0] cap;
        logic [63:0] d;
        logic [31:0] n;
        p_have  = 1'b0;
        was_err = (p_mode == MODE_ERR);
        parsed_bytes++;
        d = {56'd0, b} - {56'd0, CH_0};
        case (p_mode)
            MODE_VALUE: begin
                top = (p_sp > 0) ? p_nest[p_sp-1] : ENT_NONE;
                if (top == ENT_DKEY) begin
                    if (is_dig(b))
                        start_len(b - CH_0, 1'b1);
                    else if (b == CH_E)
                        close_nest();
                    else
                        tok_error(ERR_BAD_KEY);
                end else if (b == CH_I) begin
                    p_mode  = MODE_INT;
                    p_acc   = '0;
                    p_neg   = 1'b0;
                    p_phase = PH_SPACE;
                end else if (b == CH_L) begin
                    open_nest(ENT_LIST, KIND_LIST);
                end else if (b == CH_D) begin
                    open_nest(ENT_DKEY, KIND_DICT);
                end else if (is_dig(b)) begin
                    start_len(b - CH_0, 1'b0);
                end else if (b == CH_E && top == ENT_LIST) begin
                    close_nest();
                end else begin
                    tok_error(ERR_BAD_TYPE);
                end
            end
            MODE_INT: begin
                if (b == CH_E) begin
                    tok_set(KIND_INT, p_neg ? (64'd0 - p_acc) : p_acc, 1'b0, 1'b0);
                    p_mode = MODE_VALUE;
                    value_closed();
                end else if (p_phase == PH_SPACE &&
                             (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))) begin
                    // leading white space: skip
                end else if (p_phase == PH_SPACE && (b == CH_PLUS || b == CH_MINUS)) begin
                    p_neg   = (b == CH_MINUS);
                    p_phase = PH_SIGN;
                end else if (p_phase != PH_SKIP && is_dig(b)) begin
                    // saturate the magnitude to the signed 32-bit range
                    cap     = p_neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
                    p_phase = PH_DIGIT;
                    if (p_acc > (cap - d) / 10)
                        p_acc = cap;
                    else
                        p_acc = p_acc * 10 + d;
                end else begin
                    p_phase = PH_SKIP;
                end
            end
            MODE_LEN: begin
                if (b == CH_COLON) begin
                    n = p_acc[31:0];
                    tok_set(KIND_STR, {32'd0, n}, n == 0, p_key);
                    if (n == 0) begin
                        string_closed();
                    end else begin
                        p_mode = MODE_STR;
                        p_left = n;
                    end
                end else if (p_phase == PH_DIGIT && is_dig(b)) begin
                    if (p_acc > ({33'd0, LEN_CAP} - d) / 10)
                        tok_error(ERR_OVFL);
                    else
                        p_acc = p_acc * 10 + d;
                end else begin
                    p_phase = PH_SKIP;
                end
            end
            MODE_STR: begin
                p_left--;
                tok_set(KIND_BYTE, {56'd0, b}, p_left == 0, p_key);
                if (p_left == 0)
                    string_closed();
            end
            default: ;
        endcase
        // Unfinished value or open container on the final byte: truncation,
        // unless this byte already raised an error or the message was dead.
        if (last && !was_err && !(p_have && p_tok.kind == KIND_ERR) &&
            (p_mode != MODE_VALUE || p_sp != 0))
            tok_error(ERR_TRUNC);
        p_tok.depth   = p_sp[DEPTH_W-1:0];
        p_tok.msg_end = last;
        if (last)
            clear_parser();
        return p_have;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: mirror every accepted request, check every accepted token.
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string what);
        fail_count++;
        $display("mismatch at token %0d: %s", token_count, what);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                depth_cfg = cfg_data;
            if (s_tvalid && s_tready) begin
                if (tokenize_byte(s_tdata, s_tlast))
                    expected_tokens.push_back(p_tok);
            end
            if (m_tvalid && m_tready) begin
                if (expected_tokens.size() == 0) begin
                    flag_mismatch($sformatf("kind %0d arrived with nothing pending", m_tuser));
                end else begin
                    want = expected_tokens.pop_front();
                    if (m_tuser !== want.kind)
                        flag_mismatch($sformatf("kind %0d, want %0d", m_tuser, want.kind));
                    if (m_tdata[31:0] !== want.value)
                        flag_mismatch($sformatf("value %0h, want %0h",
                                                m_tdata[31:0], want.value));
                    if (m_tdata[32] !== want.str_end)
                        flag_mismatch($sformatf("string_end %b, want %b",
                                                m_tdata[32], want.str_end));
                    if (m_tdata[33] !== want.key)
                        flag_mismatch($sformatf("is_key %b, want %b", m_tdata[33], want.key));
                    if (m_tdata[39:34] !== want.depth)
                        flag_mismatch($sformatf("nest_depth %0d, want %0d",
                                                m_tdata[39:34], want.depth));
                    if (m_tdata[42:40] !== want.code)
                        flag_mismatch($sformatf("error_code %0d, want %0d",
                                                m_tdata[42:40], want.code));
                    if (m_tlast !== want.msg_end)
                        flag_mismatch($sformatf("message_end %b, want %b",
                                                m_tlast, want.msg_end));
                end
                token_count++;
            end
        end
    end

    // Watchdog: end the run once the cycle count passes CYCLE_LIMIT.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Token sink: draw a random stall before each token when rx_idle is set,
    // or take one long hold when a test asks for it. Count the hold here, in cycles.
    // ------------------------------------------------------------------
    initial begin
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (rx_hold_req > 0) begin
                rx_stall    = rx_hold_req;
                rx_hold_req = 0;
            end else begin
                rx_stall = rx_idle ? $urandom_range(0, 9) : 0;
            end
            if (rx_stall > 0) begin
                m_tready <= 1'b0;
                repeat (rx_stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // ------------------------------------------------------------------
    // Byte source and message builders
    // ------------------------------------------------------------------

    // Offer one byte; hold the request until the block accepts it. Lower
    // s_tvalid only when a gap is drawn, so a back-to-back request keeps
    // a single assignment per edge.
    task automatic send_byte(input logic [7:0] b, input bit last);
        int gap;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
    endtask

    task automatic send_message();
        for (int i = 0; i < msg.size(); i++)
            send_byte(msg[i], i == msg.size() - 1);
    endtask

    // Stop offering, wait for every pending token, then let the pipe settle.
    task automatic drain_tokens();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (expected_tokens.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_max_depth(input logic [DEPTH_W-1:0] v);
        drain_tokens();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            msg.push_back(s[i]);
    endfunction

    function automatic void put_int();
        int          r;
        logic [7:0]  junk;
        msg.push_back(CH_I);
        if ($urandom_range(0, 7) == 0) begin
            // values right at the saturation edges
            case ($urandom_range(0, 3))
                0:       put_text("2147483647");
                1:       put_text("2147483648");
                2:       put_text("-2147483648");
                default: put_text("-2147483649");
            endcase
        end else begin
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0) begin
                r = $urandom_range(8, 13);
                msg.push_back((r == 8) ? CH_SPACE : 8'(r));
            end
            case ($urandom_range(0, 3))
                0:       msg.push_back(CH_MINUS);
                1:       msg.push_back(CH_PLUS);
                default: ;
            endcase
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 4))
                msg.push_back(CH_0 + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 9) == 0) begin
                junk = 8'($urandom_range(0, 255));
                msg.push_back((junk == CH_E) ? CH_SPACE : junk);
            end
        end
        msg.push_back(CH_E);
    endfunction

    function automatic void put_string();
        int len;
        if ($urandom_range(0, 39) == 0) begin
            // lengths at and past the 31-bit limit
            case ($urandom_range(0, 2))
                0:       put_text("2147483647:");
                1:       put_text("2147483648:");
                default: put_text("99999999999:");
            endcase
            repeat ($urandom_range(0, 3)) msg.push_back(8'($urandom_range(0, 255)));
            return;
        end
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 5);
        if ($urandom_range(0, 15) == 0)
            msg.push_back(CH_0);
        put_text($sformatf("%0d", len));
        msg.push_back(CH_COLON);
        repeat (len) msg.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Build one message: mostly well-formed nested values, some corrupted,
    // truncated or pure noise.
    task automatic build_message();
        int  tops;
        int  r;
        int  pos;
        bit  done_value;
        msg.delete();
        plan_stk.delete();
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom_range(0, 255)));
            return;
        end
        tops = $urandom_range(1, 2);
        while (tops > 0) begin
            done_value = 1'b0;
            if (plan_stk.size() > 0 && plan_stk[$] != ENT_DVAL &&
                (msg.size() > 48 || $urandom_range(0, 3) == 0)) begin
                msg.push_back(CH_E);
                void'(plan_stk.pop_back());
                done_value = 1'b1;
            end else if (plan_stk.size() > 0 && plan_stk[$] == ENT_DKEY) begin
                put_string();
                plan_stk[plan_stk.size()-1] = ENT_DVAL;
            end else begin
                r = (plan_stk.size() >= 6 || msg.size() > 32) ?
                    $urandom_range(0, 5) : $urandom_range(0, 9);
                if (r <= 2) begin
                    put_int();
                    done_value = 1'b1;
                end else if (r <= 5) begin
                    put_string();
                    done_value = 1'b1;
                end else if (r <= 7) begin
                    msg.push_back(CH_L);
                    plan_stk.push_back(ENT_LIST);
                end else begin
                    msg.push_back(CH_D);
                    plan_stk.push_back(ENT_DKEY);
                end
            end
            if (done_value) begin
                if (plan_stk.size() == 0)
                    tops--;
                else if (plan_stk[$] == ENT_DVAL)
                    plan_stk[plan_stk.size()-1] = ENT_DKEY;
            end
        end
        r = $urandom_range(0, 9);
        if (r == 0) begin
            msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (r == 1 && msg.size() > 1) begin
            pos = $urandom_range(1, msg.size() - 1);
            while (msg.size() > pos)
                void'(msg.pop_back());
        end else if (r == 2) begin
            msg.insert($urandom_range(0, msg.size() - 1), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_text(input string s);
        msg.delete();
        put_text(s);
        send_message();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Short messages: every token kind, byte extremes, empty integer,
    // zero-length string, key string, bad key, bad type byte, truncation.
    task automatic test_tokens();
        send_text("ie");
        msg.delete();
        put_text("1:");
        msg.push_back(8'hFF);
        send_message();
        send_text("0:");
        msg.delete();
        put_text("d1:");
        msg.push_back(8'h00);
        put_text("lee");
        send_message();
        send_text("di1e");
        send_text("e");
        send_text("l");
        send_text("i 12");
    endtask

    // Depth limit at a setting of one and at the full stack depth of 32.
    task automatic test_depth_limit();
        set_max_depth(6'd1);
        send_text("ll");
        set_max_depth(6'd32);
        msg.delete();
        repeat (STK + 1) msg.push_back(CH_L);
        send_message();
        msg.delete();
        repeat (STK) msg.push_back(CH_L);
        repeat (STK) msg.push_back(CH_E);
        send_message();
    endtask

    // Hold the token side for a long stretch while bytes keep coming, so
    // the block backs up and drops s_tready; then pause until all is out.
    task automatic test_back_pressure();
        drain_tokens();
        tx_idle     = 1'b0;
        rx_hold_req = 150;
        msg.delete();
        msg.push_back(CH_L);
        put_text("30:");
        repeat (30) msg.push_back(8'($urandom_range(0, 255)));
        msg.push_back(CH_E);
        send_message();
        drain_tokens();
        tx_idle = 1'b1;
    endtask

    task automatic test_random_traffic(input int target, input logic [DEPTH_W-1:0] lim,
                                       input bit txi, input bit rxi);
        int start;
        set_max_depth(lim);
        tx_idle = txi;
        rx_idle = rxi;
        start   = parsed_bytes;
        while (parsed_bytes - start < target) begin
            build_message();
            send_message();
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        tx_idle     = 1'b1;
        rx_idle     = 1'b1;
        rx_hold_req = 0;
        depth_cfg   = MAX_DEPTH_RST;
        clear_parser();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_tokens();
        test_depth_limit();
        test_back_pressure();
        test_random_traffic(250, 6'd32, 1'b1, 1'b1);
        test_random_traffic(250, 6'd1, 1'b1, 1'b0);
        test_random_traffic(250, 6'd2, 1'b0, 1'b1);
        test_random_traffic(300, 6'($urandom_range(3, 31)), 1'b0, 1'b0);
        test_random_traffic(250, 6'd32, 1'b1, 1'b1);
        test_random_traffic(250, 6'($urandom_range(1, 32)), 1'b1, 1'b1);
        drain_tokens();

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
